// ===== rtl/cfgrc_pkg.sv =====
// Shared types and constants for the CFG reachability closure block.
// No dependencies; the top, controller and datapath refer to it by scoped names.
package cfgrc_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int BLOCK_W        = 6;
    localparam int POS_W          = 12;
    localparam int COUNT_W        = 7;

    // Command codes carried in an input beat
    typedef enum logic [1:0] {
        CMD_EDGE    = 2'd0,
        CMD_CLOSE   = 2'd1,
        CMD_BLOCK_Q = 2'd2,
        CMD_INSTR_Q = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [BLOCK_W-1:0]   src_block;
        logic [BLOCK_W-1:0]   dst_block;
        logic [POS_W-1:0]     from_pos;
        logic [POS_W-1:0]     to_pos;
    } in_beat_t;

    typedef struct packed {
        logic reachable;
        cmd_t cmd_echo;
    } out_beat_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE_RD,
        ST_EDGE_WR,
        ST_COPY,
        ST_COPY_DRAIN,
        ST_ROWK,
        ST_LATCH,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_FIN_RD,
        ST_FIN_SET,
        ST_QRD,
        ST_QANS,
        ST_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic idle;
        logic capture;
        logic edge_rd;
        logic edge_wr;
        logic copy_rd;
        logic rowk_rd;
        logic rowk_latch;
        logic scan_rd;
        logic fin_rd;
        logic fin_set;
        logic reach_clr;
        logic query_rd;
        logic query_ans;
        logic i_clr;
        logic k_clr;
        logic k_inc;
        logic out_load;
    } ctrl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic in_valid;
        cmd_t in_cmd;
        logic n_zero;
        logic i_last;
        logic k_last;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/cfg_reachability_closure.sv =====
// Top level of the CFG reachability closure block: controller plus datapath.
// Depends on cfgrc_pkg, cfgrc_ctrl, cfgrc_dp (which uses cfgrc_ram).
//
//   channel | direction | handshake          | beat
//   --------+-----------+--------------------+-----------------------------------
//   in      | input     | in_valid/in_stall  | in_data: cmd, blocks, positions
//   out     | output    | out_valid/out_stall| out_data: reachable, cmd_echo
//   cfg     | input     | cfg_valid/cfg_ready| cfg_data: block_count
//
// An edge load reads the source block's edge row, then writes it back with the new
// edge set; a query reads a closure row, then registers the answer. A close copies
// the edge rows into the closure row store, then runs one pivot pass per block.
// Reset is immediate: edge rows carry valid bits, no clearing pass is run.
// One item is worked at a time; a finished result sits in the output register
// while the next item is accepted, and out_stall only holds the final step.
module cfg_reachability_closure #(
    parameter int MAX_BLOCKS = cfgrc_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  cfgrc_pkg::in_beat_t           in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output cfgrc_pkg::out_beat_t          out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cfgrc_pkg::COUNT_W-1:0] cfg_data
);

    cfgrc_pkg::ctrl_t ctrl;
    cfgrc_pkg::stat_t stat;

    // Sequencer
    cfgrc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    // Stores and arithmetic
    cfgrc_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== rtl/cfgrc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module cfgrc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/cfgrc_ctrl.sv =====
// Controller state machine: sequences edge loads, the closure passes and queries.
// Depends on cfgrc_pkg for state, command and status types.
module cfgrc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  cfgrc_pkg::stat_t stat,
    output cfgrc_pkg::ctrl_t ctrl
);

    cfgrc_pkg::state_t state_reg;
    cfgrc_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfgrc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            cfgrc_pkg::ST_IDLE:
            begin
                ctrl.idle = 1'b1;
                if (stat.in_valid)
                begin
                    ctrl.capture = 1'b1;
                    ctrl.i_clr   = 1'b1;
                    ctrl.k_clr   = 1'b1;
                    case (stat.in_cmd)
                        cfgrc_pkg::CMD_EDGE:
                        begin
                            state_next = cfgrc_pkg::ST_EDGE_RD;
                        end
                        cfgrc_pkg::CMD_CLOSE:
                        begin
                            ctrl.reach_clr = 1'b1;
                            state_next = stat.n_zero ? cfgrc_pkg::ST_DONE
                                                     : cfgrc_pkg::ST_COPY;
                        end
                        default:
                        begin
                            state_next = cfgrc_pkg::ST_QRD;
                        end
                    endcase
                end
            end
            cfgrc_pkg::ST_EDGE_RD:
            begin
                ctrl.edge_rd = 1'b1;
                state_next = cfgrc_pkg::ST_EDGE_WR;
            end
            cfgrc_pkg::ST_EDGE_WR:
            begin
                ctrl.edge_wr = 1'b1;
                state_next = cfgrc_pkg::ST_DONE;
            end
            // copy edge rows into the closure store
            cfgrc_pkg::ST_COPY:
            begin
                ctrl.copy_rd = 1'b1;
                if (stat.i_last)
                begin
                    state_next = cfgrc_pkg::ST_COPY_DRAIN;
                end
            end
            cfgrc_pkg::ST_COPY_DRAIN:
            begin
                ctrl.i_clr = 1'b1;
                state_next = cfgrc_pkg::ST_ROWK;
            end
            // one pivot pass: fetch row k, then sweep all rows
            cfgrc_pkg::ST_ROWK:
            begin
                ctrl.rowk_rd = 1'b1;
                state_next = cfgrc_pkg::ST_LATCH;
            end
            cfgrc_pkg::ST_LATCH:
            begin
                ctrl.rowk_latch = 1'b1;
                ctrl.scan_rd    = 1'b1;
                state_next = stat.i_last ? cfgrc_pkg::ST_SCAN_DRAIN
                                         : cfgrc_pkg::ST_SCAN;
            end
            cfgrc_pkg::ST_SCAN:
            begin
                ctrl.scan_rd = 1'b1;
                if (stat.i_last)
                begin
                    state_next = cfgrc_pkg::ST_SCAN_DRAIN;
                end
            end
            cfgrc_pkg::ST_SCAN_DRAIN:
            begin
                ctrl.i_clr = 1'b1;
                if (stat.k_last)
                begin
                    state_next = cfgrc_pkg::ST_FIN_RD;
                end
                else
                begin
                    ctrl.k_inc = 1'b1;
                    state_next = cfgrc_pkg::ST_ROWK;
                end
            end
            // reach set from the entry row
            cfgrc_pkg::ST_FIN_RD:
            begin
                ctrl.fin_rd = 1'b1;
                state_next = cfgrc_pkg::ST_FIN_SET;
            end
            cfgrc_pkg::ST_FIN_SET:
            begin
                ctrl.fin_set = 1'b1;
                state_next = cfgrc_pkg::ST_DONE;
            end
            cfgrc_pkg::ST_QRD:
            begin
                ctrl.query_rd = 1'b1;
                state_next = cfgrc_pkg::ST_QANS;
            end
            cfgrc_pkg::ST_QANS:
            begin
                ctrl.query_ans = 1'b1;
                state_next = cfgrc_pkg::ST_DONE;
            end
            cfgrc_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next = cfgrc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cfgrc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/cfgrc_dp.sv =====
// Datapath: edge and closure row stores, counters, reach set, query logic, output stage.
// Depends on cfgrc_pkg and cfgrc_ram.
module cfgrc_dp #(
    parameter int MAX_BLOCKS = cfgrc_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cfgrc_pkg::ctrl_t                ctrl,
    output cfgrc_pkg::stat_t                stat,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  cfgrc_pkg::in_beat_t             in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output cfgrc_pkg::out_beat_t            out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cfgrc_pkg::COUNT_W-1:0]   cfg_data
);

    localparam int AW  = $clog2(MAX_BLOCKS);
    localparam int CW  = $clog2(MAX_BLOCKS + 1);
    localparam int XW  = (CW > cfgrc_pkg::COUNT_W) ? CW : cfgrc_pkg::COUNT_W;

    cfgrc_pkg::in_beat_t  item_reg;
    cfgrc_pkg::out_beat_t out_reg;
    logic                          out_valid_reg;
    logic [cfgrc_pkg::COUNT_W-1:0] bcount_reg;
    logic [AW-1:0]                 i_reg;
    logic [AW-1:0]                 k_reg;
    logic [AW-1:0]                 wr_addr_reg;
    logic                          copy_pend_reg;
    logic                          scan_pend_reg;
    logic [MAX_BLOCKS-1:0]         evalid_reg;
    logic [MAX_BLOCKS-1:0]         reach_reg;
    logic [MAX_BLOCKS-1:0]         rowk_reg;
    logic                          ans_reg;

    logic [XW-1:0]         bc_x;
    logic [XW-1:0]         n_x;
    logic [XW-1:0]         src_x;
    logic [XW-1:0]         dst_x;
    logic [AW-1:0]         src_idx;
    logic [AW-1:0]         dst_idx;
    logic [MAX_BLOCKS-1:0] col_mask;
    logic [MAX_BLOCKS-1:0] e_rd_data;
    logic [MAX_BLOCKS-1:0] t_rd_data;
    logic [MAX_BLOCKS-1:0] e_wr_data;
    logic [MAX_BLOCKS-1:0] t_wr_data;
    logic [AW-1:0]         e_rd_addr;
    logic [AW-1:0]         t_rd_addr;
    logic                  edge_in_range;
    logic                  e_wr_en;
    logic                  unknown;
    logic                  same_order;
    logic                  out_free;

    // Effective block count, saturated to capacity
    assign bc_x = XW'(bcount_reg);
    assign n_x  = (bc_x >= XW'(MAX_BLOCKS)) ? XW'(MAX_BLOCKS) : bc_x;

    assign src_x   = XW'(item_reg.src_block);
    assign dst_x   = XW'(item_reg.dst_block);
    assign src_idx = src_x[AW-1:0];
    assign dst_idx = dst_x[AW-1:0];

    // Columns inside the current graph
    always_comb
    begin
        for (int j = 0; j < MAX_BLOCKS; j++)
        begin
            col_mask[j] = (XW'(j) < n_x);
        end
    end

    // Edge row store
    assign edge_in_range = (src_x < XW'(MAX_BLOCKS)) && (dst_x < XW'(MAX_BLOCKS));
    assign e_wr_en   = ctrl.edge_wr && edge_in_range;
    assign e_wr_data = (evalid_reg[src_idx] ? e_rd_data : '0)
                     | ({{(MAX_BLOCKS-1){1'b0}}, 1'b1} << dst_idx);
    assign e_rd_addr = ctrl.copy_rd ? i_reg : src_idx;

    cfgrc_ram #(
        .WIDTH (MAX_BLOCKS),
        .DEPTH (MAX_BLOCKS)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (e_wr_en),
        .wr_addr (src_idx),
        .wr_data (e_wr_data),
        .rd_en   (ctrl.edge_rd || ctrl.copy_rd),
        .rd_addr (e_rd_addr),
        .rd_data (e_rd_data)
    );

    // Closure row store: row u holds the blocks reached from u over one or more edges
    always_comb
    begin
        if (copy_pend_reg)
        begin
            t_wr_data = e_rd_data & col_mask
                      & {MAX_BLOCKS{evalid_reg[wr_addr_reg]}};
        end
        else
        begin
            t_wr_data = t_rd_data | (t_rd_data[k_reg] ? rowk_reg : '0);
        end
    end

    always_comb
    begin
        if (ctrl.rowk_rd)
        begin
            t_rd_addr = k_reg;
        end
        else if (ctrl.scan_rd)
        begin
            t_rd_addr = i_reg;
        end
        else if (ctrl.fin_rd)
        begin
            t_rd_addr = '0;
        end
        else
        begin
            t_rd_addr = src_idx;
        end
    end

    cfgrc_ram #(
        .WIDTH (MAX_BLOCKS),
        .DEPTH (MAX_BLOCKS)
    ) u_clos_ram (
        .clk     (clk),
        .wr_en   (copy_pend_reg || scan_pend_reg),
        .wr_addr (wr_addr_reg),
        .wr_data (t_wr_data),
        .rd_en   (ctrl.rowk_rd || ctrl.scan_rd || ctrl.fin_rd || ctrl.query_rd),
        .rd_addr (t_rd_addr),
        .rd_data (t_rd_data)
    );

    // Query decision
    assign unknown    = (src_x >= n_x) || (dst_x >= n_x);
    assign same_order = (item_reg.cmd == cfgrc_pkg::CMD_INSTR_Q)
                     && (item_reg.src_block == item_reg.dst_block)
                     && (item_reg.to_pos > item_reg.from_pos);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcount_reg    <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            copy_pend_reg <= 1'b0;
            scan_pend_reg <= 1'b0;
            evalid_reg    <= '0;
            reach_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                bcount_reg <= cfg_data;
            end
            if (ctrl.i_clr)
            begin
                i_reg <= '0;
            end
            else if (ctrl.copy_rd || ctrl.scan_rd)
            begin
                i_reg <= i_reg + AW'(1);
            end
            if (ctrl.k_clr)
            begin
                k_reg <= '0;
            end
            else if (ctrl.k_inc)
            begin
                k_reg <= k_reg + AW'(1);
            end
            copy_pend_reg <= ctrl.copy_rd;
            scan_pend_reg <= ctrl.scan_rd;
            if (e_wr_en)
            begin
                evalid_reg[src_idx] <= 1'b1;
            end
            if (ctrl.reach_clr)
            begin
                reach_reg <= '0;
            end
            else if (ctrl.fin_set)
            begin
                reach_reg <= t_rd_data | {{(MAX_BLOCKS-1){1'b0}}, 1'b1};
            end
            if (ctrl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            item_reg <= in_data;
        end
        wr_addr_reg <= i_reg;
        if (ctrl.rowk_latch)
        begin
            rowk_reg <= t_rd_data;
        end
        if (ctrl.query_ans)
        begin
            ans_reg <= same_order || unknown || (reach_reg[src_idx] && t_rd_data[dst_idx]);
        end
        if (ctrl.out_load)
        begin
            out_reg.cmd_echo  <= item_reg.cmd;
            out_reg.reachable <= ((item_reg.cmd == cfgrc_pkg::CMD_BLOCK_Q)
                              || (item_reg.cmd == cfgrc_pkg::CMD_INSTR_Q)) && ans_reg;
        end
    end

    // Status back to the controller
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        stat.in_valid = in_valid;
        stat.in_cmd   = in_data.cmd;
        stat.n_zero   = (n_x == '0);
        stat.i_last   = (XW'(i_reg) == (n_x - XW'(1)));
        stat.k_last   = (XW'(k_reg) == (n_x - XW'(1)));
        stat.out_free = out_free;
    end

    assign in_stall  = !ctrl.idle;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

endmodule
